// ===== hw/rtl/aesxts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package aesxts_pkg;

  localparam int RK_DEPTH = 15;
  localparam logic [3:0] LAST_ROUND = 4'd14;
  localparam logic [7:0] RCON_INIT = 8'h01;
  localparam logic [7:0] TWEAK_POLY = 8'h87;
  localparam logic [7:0] GF_POLY = 8'h1b;
  localparam int CFG_IDX_W = 3;

  typedef struct packed {
    logic        action;
    logic        first_block;
    logic [63:0] sector_id;
    logic [63:0] block_low;
    logic [63:0] block_high;
    logic        last_block;
  } in_req_t;

  typedef struct packed {
    logic [63:0] result_low;
    logic [63:0] result_high;
    logic        result_last;
  } out_rsp_t;

  // Round-key write port from the key expander into the key stores.
  typedef struct packed {
    logic         we;
    logic         half;
    logic [3:0]   addr;
    logic [127:0] data;
  } kx_wr_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  function automatic logic [7:0] sbox(input logic [7:0] x);
    return SBOX[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    return INV_SBOX[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
  endfunction

  // Multiply by x in GF(2^128), byte 0 least significant.
  function automatic logic [127:0] tweak_mulx(input logic [127:0] t);
    return {t[126:0], 1'b0} ^ {120'd0, (t[127] ? TWEAK_POLY : 8'h00)};
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/aes256_xts_sector_cipher_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// AES-256 XTS block engine, one 128-bit block per request.
// Input channel: in_valid / in_stall / in_req. A request is taken when in_valid is high
// and in_stall is low. in_stall is high while a block is in flight and while round keys
// are being expanded after a key write.
// Result channel: out_valid / out_stall / out_rsp, one result per request, in order.
// Configuration: cfg_we / cfg_index / cfg_wdata write the eight 64-bit key words.
// Each write re-expands the round keys of its half: a start step, then 15 store
// writes; requests are held off until the expansion is done. Write keys only
// while the engine is idle.
// A block that does not start a sector runs 15 rounds in the shared round unit;
// its result is then formed in the done state and registered at the output.
// The next request is taken only after that, so one block is processed at a time.
// A sector start first runs the tweak encryption under the tweak key.
// Round keys are read from two 15-entry key stores, one entry per cycle.
// Reset clears the key words and the running tweak; round keys are undefined until
// the first key write of each half.
// A stalled result is held in the output register; a finished block waits for it.
module aes256_xts_sector_cipher_core
  import aesxts_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_req_t              in_req,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_rsp_t                  out_rsp,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_TWK  = 4'b0010,
    S_DAT  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t       state_r, state_nxt;
  logic [3:0]   cnt_r, cnt_nxt, cnt_inc, rd_addr;
  logic [127:0] st_r, st_nxt, blk_r, blk_nxt, tweak_r, tweak_nxt, rnd;
  logic         action_r, action_nxt, last_r, last_nxt;
  logic         out_valid_r, out_valid_nxt;
  out_rsp_t     out_r, out_nxt;
  logic         accept, kx_busy, out_free, rnd_first, rnd_last, rnd_dec;
  logic [127:0] twk_q, dat_q, rk;
  kx_wr_t       kx_wr;

  // Round-key stores, one per key half.
  logic [127:0] twk_mem [RK_DEPTH];
  logic [127:0] dat_mem [RK_DEPTH];

  aesxts_keyexp u_keyexp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .kx_wr     (kx_wr),
    .busy      (kx_busy)
  );

  // Requests are held off during expansion, so a store is never read and written
  // in the same cycle by an active block.
  always_ff @(posedge clk) begin
    if (kx_wr.we && kx_wr.half) begin
      twk_mem[kx_wr.addr] <= kx_wr.data;
    end
    if (kx_wr.we && !kx_wr.half) begin
      dat_mem[kx_wr.addr] <= kx_wr.data;
    end
    twk_q <= twk_mem[rd_addr];
    dat_q <= dat_mem[rd_addr];
  end

  assign in_stall = (state_r != S_IDLE) || kx_busy;
  assign accept = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_rsp = out_r;

  assign rnd_first = (cnt_r == 4'd0);
  assign rnd_last = (cnt_r == LAST_ROUND);
  assign rnd_dec = (state_r == S_DAT) && action_r;
  assign rk = (state_r == S_TWK) ? twk_q : dat_q;
  assign cnt_inc = cnt_r + 4'd1;

  aesxts_round u_round (
    .st    (st_r),
    .rk    (rk),
    .dec   (rnd_dec),
    .first (rnd_first),
    .last  (rnd_last),
    .nxt   (rnd)
  );

  // The key address for the next round is issued in the cycle before its use, as the store read is registered.
  // Decryption walks the store from the top entry down.
  always_comb begin
    case (state_r)
      S_IDLE: begin
        rd_addr = (!in_req.first_block && in_req.action) ? LAST_ROUND : 4'd0;
      end
      S_TWK: begin
        if (rnd_last) begin
          rd_addr = action_r ? LAST_ROUND : 4'd0;
        end else begin
          rd_addr = cnt_inc;
        end
      end
      S_DAT: begin
        if (rnd_last) begin
          rd_addr = 4'd0;
        end else begin
          rd_addr = action_r ? (LAST_ROUND - cnt_inc) : cnt_inc;
        end
      end
      default: begin
        rd_addr = 4'd0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    st_nxt = st_r;
    blk_nxt = blk_r;
    tweak_nxt = tweak_r;
    action_nxt = action_r;
    last_nxt = last_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          action_nxt = in_req.action;
          last_nxt = in_req.last_block;
          blk_nxt = {in_req.block_high, in_req.block_low};
          cnt_nxt = 4'd0;
          if (in_req.first_block) begin
            st_nxt = {64'd0, in_req.sector_id};
            state_nxt = S_TWK;
          end else begin
            st_nxt = {in_req.block_high, in_req.block_low} ^ tweak_r;
            state_nxt = S_DAT;
          end
        end
      end
      S_TWK: begin
        st_nxt = rnd;
        cnt_nxt = cnt_inc;
        if (rnd_last) begin
          // The encrypted sector number becomes the running tweak.
          tweak_nxt = rnd;
          st_nxt = blk_r ^ rnd;
          cnt_nxt = 4'd0;
          state_nxt = S_DAT;
        end
      end
      S_DAT: begin
        st_nxt = rnd;
        cnt_nxt = cnt_inc;
        if (rnd_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_nxt.result_low = st_r[63:0] ^ tweak_r[63:0];
          out_nxt.result_high = st_r[127:64] ^ tweak_r[127:64];
          out_nxt.result_last = last_r;
          out_valid_nxt = 1'b1;
          tweak_nxt = tweak_mulx(tweak_r);
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      tweak_r <= 128'd0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      tweak_r <= tweak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    st_r <= st_nxt;
    blk_r <= blk_nxt;
    action_r <= action_nxt;
    last_r <= last_nxt;
    out_r <= out_nxt;
  end

`ifndef SYNTHESIS
  a_no_accept_while_expanding: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !kx_busy)
    else $error("request taken while round keys are being expanded");

  a_sector_runs_tweak: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_req.first_block |=> state_r == S_TWK)
    else $error("sector start did not begin tweak encryption");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_DONE))
    else $error("result appeared without a finished block");

  a_key_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_addr != 4'd15)
    else $error("round-key address beyond the store");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_rsp))
    else $error("stalled result was overwritten");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/aesxts_round.sv =====
`timescale 1ns / 1ps
`default_nettype none
module aesxts_round
  import aesxts_pkg::*;
(
  input  wire logic [127:0] st,
  input  wire logic [127:0] rk,
  input  wire logic         dec,
  input  wire logic         first,
  input  wire logic         last,
  output logic      [127:0] nxt
);

  // One cipher round of the shared iterative datapath.
  logic [127:0] ss_enc, ss_dec, mix_enc, mix_dec, dec_key;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        ss_enc[8*(4*c+r) +: 8] = sbox(st[8*(4*((c+r)%4)+r) +: 8]);
        ss_dec[8*(4*((c+r)%4)+r) +: 8] = inv_sbox(st[8*(4*c+r) +: 8]);
      end
    end
  end

  assign dec_key = ss_dec ^ rk;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        logic [7:0] a0, a1, a2, a3, b0, b1, b2, b3;
        logic [7:0] b0x2, b0x4, b0x8, b1x2, b1x4, b1x8;
        logic [7:0] b2x2, b2x4, b2x8, b3x2, b3x4, b3x8;
        a0 = ss_enc[8*(4*c+r) +: 8];
        a1 = ss_enc[8*(4*c+(r+1)%4) +: 8];
        a2 = ss_enc[8*(4*c+(r+2)%4) +: 8];
        a3 = ss_enc[8*(4*c+(r+3)%4) +: 8];
        mix_enc[8*(4*c+r) +: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        b0 = dec_key[8*(4*c+r) +: 8];
        b1 = dec_key[8*(4*c+(r+1)%4) +: 8];
        b2 = dec_key[8*(4*c+(r+2)%4) +: 8];
        b3 = dec_key[8*(4*c+(r+3)%4) +: 8];
        b0x2 = xtime(b0); b0x4 = xtime(b0x2); b0x8 = xtime(b0x4);
        b1x2 = xtime(b1); b1x4 = xtime(b1x2); b1x8 = xtime(b1x4);
        b2x2 = xtime(b2); b2x4 = xtime(b2x2); b2x8 = xtime(b2x4);
        b3x2 = xtime(b3); b3x4 = xtime(b3x2); b3x8 = xtime(b3x4);
        // Coefficients 14, 11, 13, 9.
        mix_dec[8*(4*c+r) +: 8] = (b0x8 ^ b0x4 ^ b0x2) ^ (b1x8 ^ b1x2 ^ b1) ^
                                  (b2x8 ^ b2x4 ^ b2) ^ (b3x8 ^ b3);
      end
    end
  end

  always_comb begin
    if (first) begin
      nxt = st ^ rk;
    end else if (dec) begin
      nxt = last ? dec_key : mix_dec;
    end else begin
      nxt = last ? (ss_enc ^ rk) : (mix_enc ^ rk);
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/aesxts_keyexp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module aesxts_keyexp
  import aesxts_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_wdata,
  output kx_wr_t                    kx_wr,
  output logic                      busy
);

  // Key words 0..3 are the data key, 4..7 the tweak key.
  logic [63:0]  key_r [8];
  logic [1:0]   pend_r, pend_nxt;
  logic         run_r, run_nxt;
  logic         half_r, half_nxt;
  logic [3:0]   cnt_r, cnt_nxt;
  logic [255:0] win_r, win_nxt;
  logic [7:0]   rcon_r, rcon_nxt;
  logic         start;
  logic [1:0]   wr_pend;
  logic [31:0]  t, w0, w1, w2, w3, prev;

  assign start = !run_r && (pend_r != 2'b00);
  assign wr_pend = cfg_we ? (cfg_index[CFG_IDX_W-1] ? 2'b10 : 2'b01) : 2'b00;
  assign busy = run_r || (pend_r != 2'b00) || cfg_we;

  // Even steps produce a group that starts at a multiple of eight words.
  assign prev = win_r[255:224];
  always_comb begin
    if (!cnt_r[0]) begin
      t = {sbox(prev[7:0]), sbox(prev[31:24]), sbox(prev[23:16]), sbox(prev[15:8])}
          ^ {24'd0, rcon_r};
    end else begin
      t = {sbox(prev[31:24]), sbox(prev[23:16]), sbox(prev[15:8]), sbox(prev[7:0])};
    end
    w0 = win_r[31:0] ^ t;
    w1 = win_r[63:32] ^ w0;
    w2 = win_r[95:64] ^ w1;
    w3 = win_r[127:96] ^ w2;
  end

  always_comb begin
    pend_nxt = pend_r | wr_pend;
    run_nxt = run_r;
    half_nxt = half_r;
    cnt_nxt = cnt_r;
    win_nxt = win_r;
    rcon_nxt = rcon_r;
    kx_wr.we = run_r;
    kx_wr.half = half_r;
    kx_wr.addr = cnt_r;
    kx_wr.data = win_r[127:0];
    if (start) begin
      half_nxt = !pend_r[0];
      pend_nxt = (pend_r & ~(pend_r[0] ? 2'b01 : 2'b10)) | wr_pend;
      run_nxt = 1'b1;
      cnt_nxt = 4'd0;
      rcon_nxt = RCON_INIT;
      win_nxt = pend_r[0] ? {key_r[3], key_r[2], key_r[1], key_r[0]}
                          : {key_r[7], key_r[6], key_r[5], key_r[4]};
    end else if (run_r) begin
      if (cnt_r == 4'd1) begin
        kx_wr.data = win_r[255:128];
      end else if (cnt_r != 4'd0) begin
        kx_wr.data = {w3, w2, w1, w0};
        win_nxt = {w3, w2, w1, w0, win_r[255:128]};
        if (!cnt_r[0]) begin
          rcon_nxt = xtime(rcon_r);
        end
      end
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == LAST_ROUND) begin
        run_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'b00;
      run_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        key_r[i] <= 64'd0;
      end
    end else begin
      pend_r <= pend_nxt;
      run_r <= run_nxt;
      if (cfg_we) begin
        key_r[cfg_index] <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    half_r <= half_nxt;
    cnt_r <= cnt_nxt;
    win_r <= win_nxt;
    rcon_r <= rcon_nxt;
  end

endmodule
`default_nettype wire

// ===== bench/aes256_xts_sector_cipher_core_test.sv =====
`timescale 1ns / 1ps
module aes256_xts_sector_cipher_core_test;
  import aesxts_pkg::*;

  // Register indexes of the eight key words.
  localparam logic [CFG_IDX_W-1:0] REG_KEY1_W0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1_W1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1_W2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1_W3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2_W0 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2_W1 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2_W2 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2_W3 = 3'd7;

  // Request codes for the action field.
  localparam logic ACT_ENCRYPT = 1'b0;
  localparam logic ACT_DECRYPT = 1'b1;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_rsp_t out_rsp;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  always #10 clk = ~clk;

  aes256_xts_sector_cipher_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_rsp(out_rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Shadow of the block's state: key words, both expanded key schedules and the tweak.
  // The AES state is a 128-bit vector with byte i at bits 8i, as on the ports.
  logic [63:0] key_words [8];
  logic [127:0] data_sched [15];
  logic [127:0] tweak_sched [15];
  logic [127:0] model_tweak;

  out_rsp_t expected_blocks [$];
  int error_count = 0;
  int idle_cycles = 0;
  bit long_hold = 1'b0;   // the receiver sits on out_stall while this is set
  bit random_stall = 1'b0;

  function automatic logic [7:0] get_byte(logic [127:0] s, int i);
    return s[8*i +: 8];
  endfunction

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // The S-box is derived from the field inverse and the affine map, not from a table.
  function automatic logic [7:0] fwd_sub(logic [7:0] x);
    logic [7:0] inv, r;
    inv = 8'h01;
    for (int e = 0; e < 254; e++) inv = gmul(inv, x);
    r = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
        ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    return r;
  endfunction

  logic [7:0] fwd_tab [256];
  logic [7:0] rev_tab [256];

  function automatic logic [127:0] sub_rows(logic [127:0] s, bit inverse);
    logic [127:0] o;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        if (inverse) o[8*(4*((c+r)%4)+r) +: 8] = rev_tab[get_byte(s, 4*c+r)];
        else o[8*(4*c+r) +: 8] = fwd_tab[get_byte(s, 4*((c+r)%4)+r)];
      end
    return o;
  endfunction

  function automatic logic [127:0] mix_columns(logic [127:0] s, bit inverse);
    logic [127:0] o;
    logic [7:0] a [4];
    logic [7:0] m [4];
    if (inverse) m = '{8'd14, 8'd11, 8'd13, 8'd9};
    else m = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) a[r] = get_byte(s, 4*c+r);
      for (int r = 0; r < 4; r++)
        o[8*(4*c+r) +: 8] = gmul(a[r], m[0]) ^ gmul(a[(r+1)%4], m[1])
                            ^ gmul(a[(r+2)%4], m[2]) ^ gmul(a[(r+3)%4], m[3]);
    end
    return o;
  endfunction

  function automatic logic [127:0] cipher_fwd(logic [127:0] s, bit tweak_key);
    logic [127:0] k [15];
    if (tweak_key) k = tweak_sched;
    else k = data_sched;
    s ^= k[0];
    for (int r = 1; r < 14; r++) s = mix_columns(sub_rows(s, 1'b0), 1'b0) ^ k[r];
    return sub_rows(s, 1'b0) ^ k[14];
  endfunction

  function automatic logic [127:0] cipher_rev(logic [127:0] s);
    s ^= data_sched[14];
    for (int r = 13; r >= 1; r--) s = mix_columns(sub_rows(s, 1'b1) ^ data_sched[r], 1'b1);
    return sub_rows(s, 1'b1) ^ data_sched[0];
  endfunction

  // Expands one 256-bit half of the key into its 15 round keys.
  task automatic expand_half(bit tweak_half);
    logic [31:0] w [60];
    logic [31:0] t;
    logic [7:0] rc;
    logic [255:0] key;
    rc = 8'h01;
    key = tweak_half ? {key_words[7], key_words[6], key_words[5], key_words[4]}
                     : {key_words[3], key_words[2], key_words[1], key_words[0]};
    for (int i = 0; i < 8; i++) w[i] = key[32*i +: 32];
    for (int i = 8; i < 60; i++) begin
      t = w[i-1];
      if (i % 8 == 0) begin
        t = {t[7:0], t[31:8]};  // rotate bytes toward byte 0
        for (int j = 0; j < 4; j++) t[8*j +: 8] = fwd_tab[t[8*j +: 8]];
        t[7:0] ^= rc;
        rc = gmul(rc, 8'h02);
      end else if (i % 8 == 4) begin
        for (int j = 0; j < 4; j++) t[8*j +: 8] = fwd_tab[t[8*j +: 8]];
      end
      w[i] = w[i-8] ^ t;
    end
    for (int r = 0; r < 15; r++) begin
      if (tweak_half) tweak_sched[r] = {w[4*r+3], w[4*r+2], w[4*r+1], w[4*r]};
      else data_sched[r] = {w[4*r+3], w[4*r+2], w[4*r+1], w[4*r]};
    end
  endtask

  // Works out the block's result for one accepted request and advances the tweak.
  task automatic predict_block(in_req_t r);
    logic [127:0] s;
    out_rsp_t e;
    if (r.first_block) model_tweak = cipher_fwd({64'd0, r.sector_id}, 1'b1);
    s = {r.block_high, r.block_low} ^ model_tweak;
    s = (r.action == ACT_DECRYPT) ? cipher_rev(s) : cipher_fwd(s, 1'b0);
    s ^= model_tweak;
    e.result_low = s[63:0];
    e.result_high = s[127:64];
    e.result_last = r.last_block;
    expected_blocks.push_back(e);
    model_tweak = {model_tweak[126:0], 1'b0} ^ {120'd0, model_tweak[127] ? 8'h87 : 8'h00};
  endtask

  // Writes one key word; only called while the engine is idle. The caller drops cfg_we.
  task automatic write_key(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    key_words[idx] = value;
    expand_half(idx >= REG_KEY2_W0);
  endtask

  task automatic load_keys(logic [63:0] k [8]);
    for (int i = 0; i < 8; i++) write_key(CFG_IDX_W'(i), k[i]);
    cfg_we <= 1'b0;
  endtask

  // Sends one request; the predictor runs at the edge where it is taken.
  task automatic send_block(logic action, logic first, logic [63:0] sector,
                            logic [63:0] lo, logic [63:0] hi, logic last, bit gaps);
    in_req_t r;
    int gap;
    r.action = action;
    r.first_block = first;
    r.sector_id = sector;
    r.block_low = lo;
    r.block_high = hi;
    r.last_block = last;
    if (gaps) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_block(r);
    in_valid <= 1'b0;
    // The engine stalls its input after a request anyway, while the block is in flight.
    @(posedge clk);
  endtask

  // Waits until every expected result has come, then lets the engine settle.
  task automatic wait_idle();
    while (expected_blocks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Result checker: compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_blocks.size() == 0) begin
        $error("result with nothing expected: %h", out_rsp);
        error_count++;
      end else begin
        out_rsp_t e;
        e = expected_blocks.pop_front();
        if (out_rsp.result_low !== e.result_low) begin
          $error("result_low expected %h actual %h", e.result_low, out_rsp.result_low);
          error_count++;
        end
        if (out_rsp.result_high !== e.result_high) begin
          $error("result_high expected %h actual %h", e.result_high, out_rsp.result_high);
          error_count++;
        end
        if (out_rsp.result_last !== e.result_last) begin
          $error("result_last expected %b actual %b", e.result_last, out_rsp.result_last);
          error_count++;
        end
      end
    end
  end

  // Receiver stall pattern: random short and occasional long stalls, or a forced hold.
  always @(posedge clk) begin
    if (long_hold) begin
      out_stall <= 1'b1;
    end else if (random_stall) begin
      if ($urandom_range(0, 39) == 0) out_stall <= 1'b1;
      else if (out_stall && $urandom_range(0, 2) != 0) out_stall <= $urandom_range(0, 7) != 0;
      else out_stall <= $urandom_range(0, 5) == 0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: cycles with no handshake on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Key extremes and a couple of edge sectors on an unstalled receiver.
  task automatic test_directed();
    logic [63:0] k [8];
    for (int i = 0; i < 8; i++) k[i] = '0;
    load_keys(k);
    // Block before any sector start uses the zero tweak left by reset... but here
    // the keys are written first, so the round keys are always defined.
    send_block(ACT_ENCRYPT, 1'b0, '0, '0, '0, 1'b0, 1'b0);
    send_block(ACT_DECRYPT, 1'b0, '0, '1, '1, 1'b1, 1'b0);
    send_block(ACT_ENCRYPT, 1'b1, '0, '0, '0, 1'b0, 1'b0);
    send_block(ACT_ENCRYPT, 1'b0, '1, '1, '1, 1'b1, 1'b0);
    wait_idle();
    for (int i = 0; i < 8; i++) k[i] = '1;
    load_keys(k);
    send_block(ACT_DECRYPT, 1'b1, '1, '0, '1, 1'b0, 1'b0);
    send_block(ACT_ENCRYPT, 1'b0, '0, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 1'b0);
    send_block(ACT_DECRYPT, 1'b0, '0, '1, '0, 1'b1, 1'b0);
    send_block(ACT_ENCRYPT, 1'b1, 64'h8000000000000000, 64'h1, 64'h8000000000000000,
               1'b1, 1'b0);
    wait_idle();
  endtask

  // A long sector walks the tweak across its top bit so the 0x87 reduction fires.
  task automatic test_tweak_carry();
    send_block(ACT_ENCRYPT, 1'b1, 64'd1, rand64(), rand64(), 1'b0, 1'b0);
    for (int i = 0; i < 20; i++)
      send_block(i[0] ? ACT_DECRYPT : ACT_ENCRYPT, 1'b0, rand64(), rand64(), rand64(),
                 i == 19, 1'b0);
    wait_idle();
  endtask

  // Receiver holds off while the sender keeps offering; the engine must back up.
  task automatic test_backpressure();
    int hold;
    long_hold = 1'b1;
    fork
      begin
        hold = 0;
        while (hold < 300) begin
          @(posedge clk);
          hold++;
        end
        long_hold = 1'b0;
      end
      for (int i = 0; i < 6; i++)
        send_block(1'($urandom_range(0, 1)), i == 0, rand64(), rand64(), rand64(), i == 5,
                   1'b0);
    join
    wait_idle();
  endtask

  // Random sectors with random keys, gaps on both sides.
  task automatic test_random_sectors(int blocks);
    logic [63:0] k [8];
    int sent;
    int len;
    sent = 0;
    random_stall = 1'b1;
    while (sent < blocks) begin
      if ($urandom_range(0, 5) == 0) begin
        wait_idle();
        for (int i = 0; i < 8; i++) k[i] = rand64();
        load_keys(k);
      end
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      for (int b = 0; b < len; b++) begin
        // Mostly well-formed sectors; now and then a stray first or last flag.
        send_block(1'($urandom_range(0, 1)),
                   (b == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0),
                   rand64(), rand64(), rand64(),
                   (b == len - 1) ? 1'b1 : ($urandom_range(0, 19) == 0), 1'b1);
        sent++;
      end
      // Sender pauses until all results are in, now and then.
      if ($urandom_range(0, 9) == 0) while (expected_blocks.size() != 0) @(posedge clk);
    end
    random_stall = 1'b0;
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < 256; i++) fwd_tab[i] = fwd_sub(8'(i));
    for (int i = 0; i < 256; i++) rev_tab[fwd_tab[i]] = 8'(i);
    for (int i = 0; i < 8; i++) key_words[i] = '0;
    model_tweak = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_tweak_carry();
    test_backpressure();
    test_random_sectors(520);
    if (error_count == 0 && expected_blocks.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
